FILE: rtl/core/page_packet_framer_crc16_unit_defines.svh
// assertion macros for the page packet framer
// used by the checker; needs clk and arst_n in the including scope
`ifndef PAGE_PACKET_FRAMER_CRC16_UNIT_DEFINES_SVH
`define PAGE_PACKET_FRAMER_CRC16_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PPFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// next-cycle implication, disabled in reset
`define PPFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

FILE: rtl/core/ppfc_pkg.sv
// shared types, constants and crc function of the page packet framer
// no dependencies
package ppfc_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 9;
	localparam int CRC_W  = 16;
	localparam int RES_MAX = 4;
	localparam int CNT_W  = 3;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_SLOT   = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_ORDER = 1'b1;

	localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] message_type;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] payload_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_end;
		logic              run_last;
		logic              status;
	} res_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] cnt;
	} buf_load_t;

	typedef struct packed {
		logic free;
	} buf_stat_t;

	// byte-parallel crc-16 ccitt-false step, msb first
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/ppfc_in_if.sv
// input item channel of the page packet framer
// depends on ppfc_pkg
interface ppfc_in_if;
	import ppfc_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] message_type;
	logic [LEN_W-1:0]  payload_length;
	logic [BYTE_W-1:0] payload_byte;

	modport source (output valid, kind, message_type, payload_length, payload_byte,
		input ready);
	modport sink (input valid, kind, message_type, payload_length, payload_byte,
		output ready);
endinterface

FILE: rtl/core/ppfc_out_if.sv
// result channel of the page packet framer
// depends on ppfc_pkg
interface ppfc_out_if;
	import ppfc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_end;
	logic              run_last;
	logic              status;

	modport source (output valid, frame_byte, frame_end, run_last, status, input ready);
	modport sink (input valid, frame_byte, frame_end, run_last, status, output ready);
endinterface

FILE: rtl/core/ppfc_result_buf.sv
// result buffer: holds up to four results of one item and sends one per transfer
// depends on ppfc_pkg and ppfc_out_if
module ppfc_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  ppfc_pkg::buf_load_t ctl,
	input  ppfc_pkg::res_t      load_res [ppfc_pkg::RES_MAX],
	output ppfc_pkg::buf_stat_t stat,
	ppfc_out_if.source          result
);
	import ppfc_pkg::*;

	res_t             buf_q [RES_MAX];
	logic [CNT_W-1:0] cnt_q;
	logic             xfer;

	assign xfer = result.valid && result.ready;

	assign result.valid      = (cnt_q != '0);
	assign result.frame_byte = buf_q[0].frame_byte;
	assign result.frame_end  = buf_q[0].frame_end;
	assign result.run_last   = buf_q[0].run_last;
	assign result.status     = buf_q[0].status;

	assign stat.free = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= ctl.cnt;
		end else if (xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			buf_q <= load_res;
		end else if (xfer) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end
endmodule

FILE: rtl/core/page_packet_framer_crc16_unit.sv
// page packet framer with crc-16 ccitt-false, top level
// depends on ppfc_pkg, ppfc_in_if, ppfc_out_if and ppfc_result_buf
// path: an item is registered into item_s1, then its results are loaded into ppfc_result_buf
// throughput: one result per cycle while result.ready is high; a header gives 4 results, a data slot 1,
// the last slot 3, an out-of-order item 1; set by the single result port
// reset: asynchronous, clears frame state, start byte to 0 and crc to 0xffff
module page_packet_framer_crc16_unit #(
	parameter int PAGE_BYTES = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ppfc_pkg::BYTE_W-1:0] cfg_wdata,
	ppfc_in_if.sink                     item,
	ppfc_out_if.source                  result
);
	import ppfc_pkg::*;

	localparam int SW = $clog2(PAGE_BYTES + 1);
	localparam int CW = (SW > LEN_W) ? SW : LEN_W;
	localparam logic [CW-1:0] PAGE_CW   = CW'(PAGE_BYTES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(PAGE_BYTES - 1);

	logic [BYTE_W-1:0] start_byte_q;
	logic [CRC_W-1:0]  crc_q;
	logic [SW-1:0]     slot_q;
	logic [LEN_W-1:0]  len_q;
	logic              open_q;

	item_t             item_s1;
	logic              valid_s1;

	buf_load_t         ctl;
	buf_stat_t         stat;
	res_t              new_res [RES_MAX];
	logic              advance;

	logic [CW-1:0]     plen_cw;
	logic [LEN_W-1:0]  plen_c;
	logic [BYTE_W-1:0] len_lo;
	logic [BYTE_W-1:0] len_hi;
	logic [CRC_W-1:0]  hdr_crc;
	logic [BYTE_W-1:0] slot_byte;
	logic [CRC_W-1:0]  slot_crc;
	logic              last_slot;

	assign advance    = valid_s1 && stat.free;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= '0;
		end else if (cfg_we) begin
			start_byte_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind           <= item.kind;
			item_s1.message_type   <= item.message_type;
			item_s1.payload_length <= item.payload_length;
			item_s1.payload_byte   <= item.payload_byte;
		end
	end

	// header fields and crc
	always_comb begin
		plen_cw = CW'(item_s1.payload_length);
		plen_c  = (plen_cw > PAGE_CW) ? LEN_W'(PAGE_CW) : item_s1.payload_length;
		len_lo  = plen_c[7:0];
		len_hi  = {7'b0, plen_c[8]};
		hdr_crc = crc16_byte(crc16_byte(crc16_byte(CRC_INIT, item_s1.message_type),
			len_lo), len_hi);
	end

	// data slot byte and crc
	always_comb begin
		slot_byte = (CW'(slot_q) < CW'(len_q)) ? item_s1.payload_byte : PAD_BYTE;
		slot_crc  = crc16_byte(crc_q, slot_byte);
		last_slot = (slot_q == LAST_SLOT);
	end

	always_comb begin
		for (int i = 0; i < RES_MAX; i++) begin
			new_res[i] = '{frame_byte: '0, frame_end: 1'b0, run_last: 1'b0,
				status: STATUS_OK};
		end
		ctl.load = advance;
		ctl.cnt  = CNT_W'(1);
		if ((item_s1.kind == KIND_HEADER) == open_q) begin
			// header in open frame, or slot while idle
			new_res[0].run_last = 1'b1;
			new_res[0].status   = STATUS_ORDER;
		end else if (item_s1.kind == KIND_HEADER) begin
			ctl.cnt = CNT_W'(4);
			new_res[0].frame_byte = start_byte_q;
			new_res[1].frame_byte = item_s1.message_type;
			new_res[2].frame_byte = len_lo;
			new_res[3].frame_byte = len_hi;
			new_res[3].run_last   = 1'b1;
		end else if (last_slot) begin
			ctl.cnt = CNT_W'(3);
			new_res[0].frame_byte = slot_byte;
			new_res[1].frame_byte = slot_crc[7:0];
			new_res[2].frame_byte = slot_crc[15:8];
			new_res[2].frame_end  = 1'b1;
			new_res[2].run_last   = 1'b1;
		end else begin
			new_res[0].frame_byte = slot_byte;
			new_res[0].run_last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			slot_q <= '0;
			len_q  <= '0;
			open_q <= 1'b0;
		end else if (advance) begin
			if (item_s1.kind == KIND_HEADER && !open_q) begin
				crc_q  <= hdr_crc;
				slot_q <= '0;
				len_q  <= plen_c;
				open_q <= 1'b1;
			end else if (item_s1.kind == KIND_SLOT && open_q) begin
				crc_q <= slot_crc;
				if (last_slot) begin
					slot_q <= '0;
					open_q <= 1'b0;
				end else begin
					slot_q <= slot_q + SW'(1);
				end
			end
		end
	end

	ppfc_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.load_res (new_res),
		.stat     (stat),
		.result   (result)
	);
endmodule

FILE: rtl/core/ppfc_checker.sv
// port-level checker for the page packet framer, bound to the top level
// depends on page_packet_framer_crc16_unit_defines.svh
`include "page_packet_framer_crc16_unit_defines.svh"

module ppfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_frame_byte,
	input logic       res_frame_end,
	input logic       res_run_last,
	input logic       res_status
);
	// stalled result holds
	`PPFC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(res_frame_byte) && $stable(res_frame_end) && $stable(res_run_last) && $stable(res_status))

	// frame end closes the item and is never an error
	`PPFC_ASSERT_NOW(a_end_last, res_valid && res_frame_end, res_run_last && !res_status)

	// an error result stands alone with a zero byte
	`PPFC_ASSERT_NOW(a_err_form, res_valid && res_status,
		res_run_last && !res_frame_end && (res_frame_byte == 8'h00))
endmodule

bind page_packet_framer_crc16_unit ppfc_checker u_ppfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_frame_byte (result.frame_byte),
	.res_frame_end  (result.frame_end),
	.res_run_last   (result.run_last),
	.res_status     (result.status)
);

FILE: tb/tb_page_packet_framer_crc16_unit.sv
// testbench for the page packet framer: directed and random frames through the item channel
// bytes, frame end, run end and status checked against a crc-16 frame predictor
// depends on ppfc_pkg, ppfc_in_if, ppfc_out_if and page_packet_framer_crc16_unit
module tb_page_packet_framer_crc16_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ppfc_pkg::*;

	localparam int PAGE = 256;
	localparam int TOTAL_ITEMS = 430;
	localparam int MAX_PRINTS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;

	ppfc_in_if in_ch();
	ppfc_out_if out_ch();

	page_packet_framer_crc16_unit #(
		.PAGE_BYTES(PAGE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(in_ch),
		.result(out_ch)
	);

	// predictor state
	logic [CRC_W-1:0] crc_now = CRC_INIT;
	logic [BYTE_W-1:0] start_byte_exp = 8'h00;
	int slot_pos = 0;
	int frame_len = 0;
	bit frame_busy = 1'b0;

	res_t frame_bytes_due[$];
	res_t head_res;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;
	int rx_hold = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 2);
		end else if (r < 97) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CRC_W-1:0] crc_after(input logic [CRC_W-1:0] c,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		logic fb;
		r = c;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = r[CRC_W-1] ^ b[i];
			r = {r[CRC_W-2:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic void due_byte(input logic [BYTE_W-1:0] b, input logic fend,
		input logic last, input logic st);
		res_t r;
		r.frame_byte = b;
		r.frame_end = fend;
		r.run_last = last;
		r.status = st;
		frame_bytes_due.push_back(r);
	endfunction

	function automatic void predict_frame_bytes(input item_t it);
		logic [15:0] len;
		logic [BYTE_W-1:0] b;
		if (it.kind == KIND_HEADER) begin
			if (frame_busy) begin
				due_byte(8'h00, 1'b0, 1'b1, STATUS_ORDER);
			end else begin
				len = (it.payload_length > PAGE) ? 16'(PAGE) : 16'(it.payload_length);
				crc_now = crc_after(crc_after(crc_after(CRC_INIT, it.message_type),
					len[7:0]), len[15:8]);
				frame_len = int'(len);
				slot_pos = 0;
				frame_busy = 1'b1;
				due_byte(start_byte_exp, 1'b0, 1'b0, STATUS_OK);
				due_byte(it.message_type, 1'b0, 1'b0, STATUS_OK);
				due_byte(len[7:0], 1'b0, 1'b0, STATUS_OK);
				due_byte(len[15:8], 1'b0, 1'b1, STATUS_OK);
			end
		end else begin
			if (!frame_busy) begin
				due_byte(8'h00, 1'b0, 1'b1, STATUS_ORDER);
			end else begin
				b = (slot_pos < frame_len) ? it.payload_byte : PAD_BYTE;
				crc_now = crc_after(crc_now, b);
				slot_pos++;
				if (slot_pos >= PAGE) begin
					due_byte(b, 1'b0, 1'b0, STATUS_OK);
					due_byte(crc_now[7:0], 1'b0, 1'b0, STATUS_OK);
					due_byte(crc_now[15:8], 1'b1, 1'b1, STATUS_OK);
					frame_busy = 1'b0;
					slot_pos = 0;
				end else begin
					due_byte(b, 1'b0, 1'b1, STATUS_OK);
				end
			end
		end
	endfunction

	function automatic item_t mk_header(input logic [BYTE_W-1:0] mt,
		input logic [LEN_W-1:0] len);
		item_t it;
		it.kind = KIND_HEADER;
		it.message_type = mt;
		it.payload_length = len;
		it.payload_byte = BYTE_W'($urandom);
		return it;
	endfunction

	function automatic item_t mk_slot(input logic [BYTE_W-1:0] pb);
		item_t it;
		it.kind = KIND_SLOT;
		it.message_type = BYTE_W'($urandom);
		it.payload_length = LEN_W'($urandom);
		it.payload_byte = pb;
		return it;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hFF;
		end
		return BYTE_W'($urandom);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS) begin
			$display("mismatch at %0t ns, result %0d: %s", $realtime, results_seen, msg);
		end
		mismatches++;
	endtask

	task automatic send_item(input item_t it);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= it.kind;
		in_ch.message_type <= it.message_type;
		in_ch.payload_length <= it.payload_length;
		in_ch.payload_byte <= it.payload_byte;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_frame_bytes(it);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_byte(input logic [BYTE_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_byte_exp = v;
	endtask

	// sends slots until the open frame closes, with stray headers mixed in
	task automatic fill_page(input int stray_pct);
		while (frame_busy) begin
			if ($urandom_range(0, 99) < stray_pct) begin
				send_item(mk_header(BYTE_W'($urandom), LEN_W'($urandom)));
			end
			send_item(mk_slot(pick_byte()));
		end
	endtask

	task automatic test_order_errors();
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		send_item(mk_slot(8'h5A));
		send_item(mk_header(8'hFF, 9'h1FF));
		send_item(mk_header(8'h00, 9'h000));
		send_item(mk_slot(8'h00));
		send_item(mk_slot(8'hFF));
		fill_page(0);
		send_item(mk_slot(8'hA5));
		wait_idle();
	endtask

	// opens a short frame under a new start byte; the tail keeps filling it
	task automatic test_start_byte();
		logic [BYTE_W-1:0] code;
		logic [LEN_W-1:0] len;
		code = BYTE_W'($urandom_range(1, 255));
		len = LEN_W'($urandom_range(1, 120));
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		write_start_byte(code);
		send_item(mk_header(BYTE_W'($urandom), len));
		wait_idle();
	endtask

	// slots with padding past the length and stray headers until the item budget is spent
	task automatic test_random_tail();
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			if (!frame_busy) begin
				send_item(mk_header(BYTE_W'($urandom), LEN_W'($urandom_range(0, 511))));
			end else if ($urandom_range(0, 99) < 3) begin
				send_item(mk_header(BYTE_W'($urandom), LEN_W'($urandom)));
			end else begin
				send_item(mk_slot(pick_byte()));
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (rx_stalls && $urandom_range(0, 4) == 0) begin
				rx_hold <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, byte %02h", out_ch.frame_byte));
			end else begin
				head_res = frame_bytes_due.pop_front();
				if (out_ch.frame_byte !== head_res.frame_byte) begin
					report_mismatch($sformatf("frame_byte %02h, want %02h",
						out_ch.frame_byte, head_res.frame_byte));
				end
				if (out_ch.frame_end !== head_res.frame_end) begin
					report_mismatch($sformatf("frame_end %b, want %b",
						out_ch.frame_end, head_res.frame_end));
				end
				if (out_ch.run_last !== head_res.run_last) begin
					report_mismatch($sformatf("run_last %b, want %b",
						out_ch.run_last, head_res.run_last));
				end
				if (out_ch.status !== head_res.status) begin
					report_mismatch($sformatf("status bit %b, want %b",
						out_ch.status, head_res.status));
				end
			end
			results_seen++;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_HEADER;
		in_ch.message_type = '0;
		in_ch.payload_length = '0;
		in_ch.payload_byte = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_order_errors();
		test_start_byte();
		test_random_tail();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && frame_bytes_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
